>>> rtl/core/sssc_pkg.sv
// Shared types, constants and command/status codes for the servo slew and sweep controller.
// No dependencies; sssc_state_ram, sssc_servo_update and the top level import this package.
`default_nettype none

package sssc_pkg;

    // number of servo slots and the index width that addresses them
    localparam int SERVO_COUNT = 2;
    localparam int SERVO_IW    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    // limits and home position
    localparam logic [7:0] MAX_DEG   = 8'd180;
    localparam logic [7:0] MAX_SPEED = 8'd20;
    localparam logic [7:0] HOME_DEG  = 8'd90;

    // payload length needed by set and sweep commands
    localparam logic [7:0] LEN_SET   = 8'd2;
    localparam logic [7:0] LEN_SWEEP = 8'd5;

    // command codes
    localparam logic [2:0] CMD_SET_POS   = 3'd0;
    localparam logic [2:0] CMD_SET_SPEED = 3'd1;
    localparam logic [2:0] CMD_SWEEP     = 3'd2;
    localparam logic [2:0] CMD_GET_POS   = 3'd3;
    localparam logic [2:0] CMD_GET_SPEED = 3'd4;
    localparam logic [2:0] CMD_TICK      = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MOVED     = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // one memory word per servo
    typedef struct packed {
        logic [7:0] position;
        logic [7:0] target;
        logic [4:0] speed_limit;
        logic       sweep_on;
        logic [7:0] bound_low;
        logic [7:0] bound_high;
        logic [4:0] sweep_stride;
        logic       heading_down;
    } t_servo_state;

    localparam t_servo_state STATE_RESET = '{
        position:     HOME_DEG,
        target:       HOME_DEG,
        speed_limit:  5'd0,
        sweep_on:     1'b0,
        bound_low:    8'd0,
        bound_high:   MAX_DEG,
        sweep_stride: 5'd1,
        heading_down: 1'b0
    };

    // command fields held for the length of one transaction
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] payload_len;
        logic [7:0] servo_index;
        logic [7:0] value;
        logic [7:0] sweep_enable;
        logic [7:0] sweep_low;
        logic [7:0] sweep_high;
        logic [7:0] sweep_increment;
    } t_cmd_fields;

    // result of one read-modify-write step
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] reading;
    } t_update_res;

endpackage

`default_nettype wire

>>> rtl/core/sssc_if.sv
// Valid/ready channel interfaces for command and result transactions.
// No dependencies.
`default_nettype none

interface sssc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] payload_len;
    logic [7:0] servo_index;
    logic [7:0] value;
    logic [7:0] sweep_enable;
    logic [7:0] sweep_low;
    logic [7:0] sweep_high;
    logic [7:0] sweep_increment;

    modport source (
        output valid, cmd, payload_len, servo_index, value,
               sweep_enable, sweep_low, sweep_high, sweep_increment,
        input  ready
    );
    modport sink (
        input  valid, cmd, payload_len, servo_index, value,
               sweep_enable, sweep_low, sweep_high, sweep_increment,
        output ready
    );
endinterface

interface sssc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] servo;
    logic [7:0] reading;
    logic       last;

    modport source (
        output valid, status, servo, reading, last,
        input  ready
    );
    modport sink (
        input  valid, status, servo, reading, last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/sssc_state_ram.sv
// Per-servo state memory: one write port, one registered read port, valid bit per entry.
// Depends on sssc_pkg; an entry never written reads as the reset state.
`default_nettype none

module sssc_state_ram (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_rd_en,
    input  wire logic [sssc_pkg::SERVO_IW-1:0]   i_rd_addr,
    input  wire logic                            i_wr_en,
    input  wire logic [sssc_pkg::SERVO_IW-1:0]   i_wr_addr,
    input  wire sssc_pkg::t_servo_state          i_wr_data,
    output sssc_pkg::t_servo_state               o_rd_data
);
    import sssc_pkg::*;

    t_servo_state               r_mem [SERVO_COUNT];
    logic [SERVO_COUNT-1:0]     r_valid;
    t_servo_state               r_rd_data;
    logic                       r_rd_valid;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : STATE_RESET;

endmodule

`default_nettype wire

>>> rtl/core/sssc_servo_update.sv
// Next-state and result logic for one servo entry under one command.
// Depends on sssc_pkg; purely combinational.
`default_nettype none

module sssc_servo_update (
    input  wire sssc_pkg::t_cmd_fields   i_fields,
    input  wire sssc_pkg::t_servo_state  i_state,
    output sssc_pkg::t_servo_state       o_state,
    output sssc_pkg::t_update_res        o_res
);
    import sssc_pkg::*;

    logic [7:0]        lo_clamp;
    logic [7:0]        hi_clamp;
    logic [7:0]        lo_sorted;
    logic [7:0]        hi_sorted;
    logic [4:0]        stride;
    logic [7:0]        target_clamp;
    logic [4:0]        speed_clamp;
    logic signed [9:0] sweep_next;
    logic [7:0]        tick_target;
    logic              tick_heading;
    logic [8:0]        up_pos;
    logic signed [9:0] down_pos;
    logic [7:0]        slew_pos;

    // clamps for set and sweep commands
    always_comb begin
        target_clamp = (i_fields.value > MAX_DEG) ? MAX_DEG : i_fields.value;
        speed_clamp  = (i_fields.value > MAX_SPEED) ? MAX_SPEED[4:0] : i_fields.value[4:0];
        lo_clamp     = (i_fields.sweep_low > MAX_DEG) ? MAX_DEG : i_fields.sweep_low;
        hi_clamp     = (i_fields.sweep_high > MAX_DEG) ? MAX_DEG : i_fields.sweep_high;
        lo_sorted    = (lo_clamp > hi_clamp) ? hi_clamp : lo_clamp;
        hi_sorted    = (lo_clamp > hi_clamp) ? lo_clamp : hi_clamp;
        if (i_fields.sweep_increment == 8'd0) begin
            stride = 5'd1;
        end else if (i_fields.sweep_increment > MAX_SPEED) begin
            stride = MAX_SPEED[4:0];
        end else begin
            stride = i_fields.sweep_increment[4:0];
        end
    end

    // sweep step on tick, bouncing at the bounds
    always_comb begin
        tick_target  = i_state.target;
        tick_heading = i_state.heading_down;
        sweep_next   = i_state.heading_down
                     ? $signed({2'b00, i_state.position}) - $signed({5'd0, i_state.sweep_stride})
                     : $signed({2'b00, i_state.position}) + $signed({5'd0, i_state.sweep_stride});
        if (i_state.sweep_on) begin
            if (sweep_next >= $signed({2'b00, i_state.bound_high})) begin
                tick_target  = i_state.bound_high;
                tick_heading = 1'b1;
            end else if (sweep_next <= $signed({2'b00, i_state.bound_low})) begin
                tick_target  = i_state.bound_low;
                tick_heading = 1'b0;
            end else begin
                tick_target  = sweep_next[7:0];
            end
        end
    end

    // speed-limited slew toward the target
    always_comb begin
        up_pos   = {1'b0, i_state.position} + {4'd0, i_state.speed_limit};
        down_pos = $signed({2'b00, i_state.position}) - $signed({5'd0, i_state.speed_limit});
        if (i_state.speed_limit == 5'd0) begin
            slew_pos = tick_target;
        end else if (i_state.position < tick_target) begin
            slew_pos = (up_pos > {1'b0, tick_target}) ? tick_target : up_pos[7:0];
        end else begin
            slew_pos = (down_pos < $signed({2'b00, tick_target})) ? tick_target : down_pos[7:0];
        end
    end

    // command dispatch
    always_comb begin
        o_state       = i_state;
        o_res.status  = ST_OK;
        o_res.reading = 8'd0;
        case (i_fields.cmd)
            CMD_SET_POS: begin
                o_state.sweep_on = 1'b0;
                o_state.target   = target_clamp;
                o_res.reading    = target_clamp;
            end
            CMD_SET_SPEED: begin
                o_state.speed_limit = speed_clamp;
                o_res.reading       = {3'd0, speed_clamp};
            end
            CMD_SWEEP: begin
                o_state.sweep_on     = (i_fields.sweep_enable != 8'd0);
                o_state.bound_low    = lo_sorted;
                o_state.bound_high   = hi_sorted;
                o_state.sweep_stride = stride;
                if (i_state.position <= lo_sorted) begin
                    o_state.heading_down = 1'b0;
                end else if (i_state.position >= hi_sorted) begin
                    o_state.heading_down = 1'b1;
                end
            end
            CMD_GET_POS: begin
                o_res.reading = i_state.position;
            end
            CMD_GET_SPEED: begin
                o_res.reading = {3'd0, i_state.speed_limit};
            end
            CMD_TICK: begin
                o_state.target       = tick_target;
                o_state.heading_down = tick_heading;
                if (i_state.position != tick_target) begin
                    o_state.position = slew_pos;
                    o_res.status     = ST_MOVED;
                    o_res.reading    = slew_pos;
                end else begin
                    o_res.reading    = i_state.position;
                end
            end
            default: begin
                o_res.reading = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/servo_slew_sweep_controller_top.sv
// Top level of the servo slew and sweep controller: sequencer, state memory, result register.
// Depends on sssc_pkg, sssc_if, sssc_state_ram and sssc_servo_update.
//
// Usage:
//   i_cmd carries command transactions (set position, set speed, sweep set-up,
//   get positions, get speeds, tick); o_res carries result transactions with
//   status, servo, reading and last. Both use valid/ready.
//   Per-servo state lives in a small memory with a registered read port.
//   Each result takes a read step followed by a modify/write step: for a set or
//   sweep command the sequencer checks the command while reading the entry,
//   then modifies it, writes it back and loads the result. Gets and ticks walk
//   the servos in order, a read and a modify/write step per servo. Short-payload
//   and bad-index errors load an error result; unused command codes are dropped.
//   One command is in flight at a time; i_cmd.ready is high only when idle.
//   Results leave through an output register; when the receiver stalls the
//   sequencer holds in its write step until the register frees, so no result
//   is lost or repeated.
//   Reset clears the sequencer, the output register and the per-entry valid
//   bits; every servo then reads as position and target 90, speed 0, sweep off
//   with bounds 0..180, stride 1, heading up. No clearing pass is needed.
`default_nettype none

module servo_slew_sweep_controller_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sssc_cmd_if.sink   i_cmd,
    sssc_res_if.source o_res
);
    import sssc_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    localparam logic [SERVO_IW-1:0] LAST_SERVO = SERVO_IW'(SERVO_COUNT - 1);

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    t_cmd_fields         r_item;
    logic [SERVO_IW-1:0] r_k;
    logic [SERVO_IW-1:0] n_k;
    logic [1:0]          r_err_status;
    logic [1:0]          n_err_status;

    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [2:0]          r_out_servo;
    logic [7:0]          r_out_reading;
    logic                r_out_last;

    logic                unit_cmd;
    logic                multi_cmd;
    logic                short_len;
    logic                bad_index;
    logic                slot_free;
    logic                rd_en;
    logic [SERVO_IW-1:0] rd_addr;
    logic                wr_en;
    logic                item_done;
    t_servo_state        rd_state;
    t_servo_state        upd_state;
    t_update_res         upd_res;

    // command classification
    always_comb begin
        unit_cmd  = r_item.cmd inside {CMD_SET_POS, CMD_SET_SPEED, CMD_SWEEP};
        multi_cmd = r_item.cmd inside {CMD_GET_POS, CMD_GET_SPEED, CMD_TICK};
        short_len = r_item.payload_len < ((r_item.cmd == CMD_SWEEP) ? LEN_SWEEP : LEN_SET);
        bad_index = r_item.servo_index >= 8'(SERVO_COUNT);
        slot_free = !r_out_valid || o_res.ready;
        item_done = unit_cmd || (r_k == LAST_SERVO);
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_err_status = r_err_status;
        rd_en        = 1'b0;
        rd_addr      = r_k;
        wr_en        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (unit_cmd && short_len) begin
                    n_err_status = ST_SHORT;
                    n_state      = S_ERR;
                end else if (unit_cmd && bad_index) begin
                    n_err_status = ST_BAD_INDEX;
                    n_state      = S_ERR;
                end else if (unit_cmd) begin
                    n_k     = r_item.servo_index[SERVO_IW-1:0];
                    rd_en   = 1'b1;
                    rd_addr = r_item.servo_index[SERVO_IW-1:0];
                    n_state = S_MOD;
                end else if (multi_cmd) begin
                    n_k     = '0;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = S_MOD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (slot_free) begin
                    wr_en = !(r_item.cmd inside {CMD_GET_POS, CMD_GET_SPEED});
                    if (item_done) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_err_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_err_status <= n_err_status;
        end
    end

    // capture command fields on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_item.cmd             <= i_cmd.cmd;
            r_item.payload_len     <= i_cmd.payload_len;
            r_item.servo_index     <= i_cmd.servo_index;
            r_item.value           <= i_cmd.value;
            r_item.sweep_enable    <= i_cmd.sweep_enable;
            r_item.sweep_low       <= i_cmd.sweep_low;
            r_item.sweep_high      <= i_cmd.sweep_high;
            r_item.sweep_increment <= i_cmd.sweep_increment;
        end
    end

    // state memory
    sssc_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_k),
        .i_wr_data (upd_state),
        .o_rd_data (rd_state)
    );

    // per-entry modify logic
    sssc_servo_update u_update (
        .i_fields (r_item),
        .i_state  (rd_state),
        .o_state  (upd_state),
        .o_res    (upd_res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free && (r_state == S_MOD || r_state == S_ERR)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (slot_free && r_state == S_MOD) begin
            r_out_status  <= upd_res.status;
            r_out_servo   <= 3'(r_k);
            r_out_reading <= upd_res.reading;
            r_out_last    <= item_done;
        end else if (slot_free && r_state == S_ERR) begin
            r_out_status  <= r_err_status;
            r_out_servo   <= 3'd0;
            r_out_reading <= 8'd0;
            r_out_last    <= 1'b1;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.servo   = r_out_servo;
    assign o_res.reading = r_out_reading;
    assign o_res.last    = r_out_last;

endmodule

`default_nettype wire
